### sv/s2da_pkg.sv
// ----------------------------------------------------------------------------
// s2da_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package s2da_pkg;

  // Default width of the converted integer
  localparam int unsigned VALUE_WIDTH_DEF = 64;

  // Fixed field widths
  localparam int unsigned IN_W   = 64;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned LEN_W  = 5;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  // Longest text: sign plus twenty digits never occurs, twenty is the cap
  localparam logic [LEN_W-1:0] MAX_TEXT = 5'd20;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEN,
    ST_EMIT
  } state_t;

  // Control word shared by every digit cell
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 correct, then shift in one binary bit
    logic shift;   // take the lower neighbor's digit
  } cell_ctrl_t;

endpackage

### sv/s2da_digit_cell.sv
// ----------------------------------------------------------------------------
// s2da_digit_cell
// One BCD digit of the conversion row. In dabble mode it corrects the digit
// (add 3 when 5 or more), shifts in the bit from its lower neighbor and passes
// its top bit up. In shift mode it takes the lower neighbor's whole digit.
// ----------------------------------------------------------------------------
module s2da_digit_cell (
  input  logic                   clk,
  input  s2da_pkg::cell_ctrl_t   ctrl,
  input  logic                   bit_in,
  input  logic [3:0]             digit_in,
  output logic                   carry_out,
  output logic [3:0]             digit_out
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  // Add-3 correction ahead of the shift
  assign adj       = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign carry_out = adj[3];
  assign digit_out = digit_r;

  // Next digit
  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

### sv/signed_to_decimal_ascii.sv
// Flow: after an input transaction the value is shifted bit by bit through the
//   digit cell row (ST_CONV), the text length is set (ST_LEN), then characters load
//   the output register (ST_EMIT), one character per cycle when out_stall is low.
//   A new input is taken only in ST_IDLE, once the last character of the previous
//   text has been loaded into the output register.
// Reset: synchronous, active low; clears the controller and output valid.
// ----------------------------------------------------------------------------
// signed_to_decimal_ascii
// Converts a signed integer to decimal ASCII text, one character per output
// transaction, most significant first, using a row of double-dabble cells.
// ----------------------------------------------------------------------------
module signed_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = s2da_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [s2da_pkg::IN_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [s2da_pkg::CHAR_W-1:0]  out_character,
  output logic [s2da_pkg::LEN_W-1:0]   out_text_length,
  output logic                          out_is_last
);

  // Digit count for a magnitude up to 2^(VALUE_WIDTH-1)
  localparam int unsigned NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned IDX_W = $clog2(NDIG);
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  typedef logic [IDX_W-1:0] idx_t;

  s2da_pkg::state_t state_r, state_nxt;
  s2da_pkg::cell_ctrl_t cell_ctrl;

  logic [VALUE_WIDTH-1:0]    mag_r, mag_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      neg_r, neg_nxt;
  logic                      sign_pend_r, sign_pend_nxt;
  idx_t                      top_r, top_nxt;
  logic [s2da_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [s2da_pkg::LEN_W-1:0] rem_r, rem_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [s2da_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic [s2da_pkg::LEN_W-1:0]  olen_r, olen_nxt;
  logic                       last_r, last_nxt;

  logic [VALUE_WIDTH-1:0] raw;
  logic                   in_neg;
  logic                   out_load;
  logic                   lz_found;
  idx_t                   top_scan;

  logic [NDIG:0]    carry;
  logic [3:0]       digit [NDIG];

  assign raw    = in_value[VALUE_WIDTH-1:0];
  assign in_neg = raw[VALUE_WIDTH-1];

  // Digit cell row: bits enter at cell 0 and move toward the top digit
  assign carry[0] = mag_r[VALUE_WIDTH-1];

  for (genvar g = 0; g < NDIG; g++) begin : g_cell
    logic [3:0] below;
    if (g == 0) begin : g_bottom
      assign below = 4'd0;
    end else begin : g_upper
      assign below = digit[g-1];
    end
    s2da_digit_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .bit_in    (carry[g]),
      .digit_in  (below),
      .carry_out (carry[g+1]),
      .digit_out (digit[g])
    );
  end

  // Highest nonzero digit, zero counts as one digit
  always_comb begin
    top_scan = '0;
    lz_found = 1'b0;
    for (int k = 0; k < NDIG; k++) begin
      if (digit[k] != 4'd0) begin
        top_scan = idx_t'(k);
        lz_found = 1'b1;
      end
    end
  end

  // In the emit state, the output register loads when empty or being taken
  assign out_load = (state_r == s2da_pkg::ST_EMIT) && (!out_valid_r || !out_stall);

  // Controller: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    top_nxt       = top_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    cell_ctrl     = '0;
    in_stall      = 1'b1;
    char_nxt      = char_r;
    olen_nxt      = olen_r;
    last_nxt      = last_r;
    unique case (state_r)
      s2da_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          neg_nxt         = in_neg;
          mag_nxt         = in_neg ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
          cnt_nxt         = CNT_W'(VALUE_WIDTH - 1);
          cell_ctrl.clear = 1'b1;
          state_nxt       = s2da_pkg::ST_CONV;
        end
      end
      s2da_pkg::ST_CONV: begin
        cell_ctrl.dabble = 1'b1;
        mag_nxt          = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        cnt_nxt          = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = s2da_pkg::ST_LEN;
        end
      end
      s2da_pkg::ST_LEN: begin
        top_nxt       = lz_found ? top_scan : '0;
        len_nxt       = s2da_pkg::LEN_W'(top_nxt) + 5'd1 + {4'd0, neg_r};
        rem_nxt       = len_nxt;
        sign_pend_nxt = neg_r;
        state_nxt     = s2da_pkg::ST_EMIT;
      end
      s2da_pkg::ST_EMIT: begin
        if (out_load) begin
          olen_nxt = len_r;
          last_nxt = (rem_r == 5'd1);
          rem_nxt  = rem_r - 5'd1;
          if (sign_pend_r) begin
            char_nxt      = s2da_pkg::CHAR_MINUS;
            sign_pend_nxt = 1'b0;
          end else begin
            char_nxt        = s2da_pkg::CHAR_ZERO + {3'd0, digit[top_r]};
            cell_ctrl.shift = 1'b1;
          end
          if (rem_r == 5'd1) begin
            state_nxt = s2da_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = s2da_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= s2da_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    cnt_r       <= cnt_nxt;
    neg_r       <= neg_nxt;
    sign_pend_r <= sign_pend_nxt;
    top_r       <= top_nxt;
    len_r       <= len_nxt;
    rem_r       <= rem_nxt;
    char_r      <= char_nxt;
    olen_r      <= olen_nxt;
    last_r      <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_character   = char_r;
  assign out_text_length = olen_r;
  assign out_is_last     = last_r;

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_text_length >= 5'd1 && out_text_length <= s2da_pkg::MAX_TEXT))
    else $error("text length out of range");

  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == s2da_pkg::CHAR_MINUS ||
                   (out_character >= s2da_pkg::CHAR_ZERO &&
                    out_character <= s2da_pkg::CHAR_NINE)))
    else $error("character is neither sign nor digit");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != s2da_pkg::ST_IDLE) |-> in_stall)
    else $error("input taken while a conversion is in flight");

  a_conv_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == s2da_pkg::ST_CONV) |=>
      (state_r == s2da_pkg::ST_CONV || state_r == s2da_pkg::ST_LEN))
    else $error("conversion left early");

  // The top digit never overflows while bits are shifted in
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == s2da_pkg::ST_CONV) |-> !carry[NDIG])
    else $error("digit row overflow");
`endif

endmodule

### sim/signed_to_decimal_ascii_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_to_decimal_ascii_test
// Drives signed 64-bit integers into the decimal text converter and checks
// every character transaction against an in-bench prediction of the digit
// string: sign, digit order, text length and last-character marking.
// Sender runs in random bursts and gaps; receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module signed_to_decimal_ascii_test;

  localparam int unsigned VW = s2da_pkg::VALUE_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 455;
  localparam int SETTLE_CYCLES = 200;

  // One expected character transaction
  typedef struct packed {
    logic [s2da_pkg::CHAR_W-1:0] char_code;
    logic [s2da_pkg::LEN_W-1:0]  text_len;
    logic                        last_char;
  } text_char_t;

  // One pending input; hold_for_drain waits for all text to come out first
  typedef struct {
    logic [s2da_pkg::IN_W-1:0] value;
    bit                        hold_for_drain;
  } pending_value_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [s2da_pkg::IN_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [s2da_pkg::CHAR_W-1:0] out_character;
  logic [s2da_pkg::LEN_W-1:0] out_text_length;
  logic out_is_last;

  pending_value_t pending_values[$];
  text_char_t expected_chars[$];
  int errors = 0;

  // Sender burst shaping
  int burst_left = 0;
  int gap_left = 0;

  // Receiver stall pattern
  int stall_mode = 0;
  int stall_mode_left = 0;
  int stall_phase = 0;

  signed_to_decimal_ascii #(.VALUE_WIDTH(VW)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_character  (out_character),
    .out_text_length(out_text_length),
    .out_is_last    (out_is_last)
  );

  always #2 clk = ~clk;

  // Predict the decimal text of one value and queue its characters
  function automatic void push_decimal_text(logic [s2da_pkg::IN_W-1:0] value);
    logic [s2da_pkg::IN_W-1:0] mask;
    logic [s2da_pkg::IN_W-1:0] raw;
    logic [s2da_pkg::IN_W-1:0] mag;
    logic            negative;
    logic [3:0]      digits[20];
    int              ndig;
    int              total;
    int              pos;
    text_char_t      tc;
    mask = {s2da_pkg::IN_W{1'b1}} >> (s2da_pkg::IN_W - VW);
    raw = value & mask;
    negative = raw[VW-1];
    mag = negative ? ((~raw + 1'b1) & mask) : raw;
    ndig = 0;
    do begin
      if (ndig < 20) begin
        digits[ndig] = 4'(mag % 64'd10);
        ndig++;
      end
      mag = mag / 64'd10;
    end while (mag != 0);
    total = ndig + (negative ? 1 : 0);
    if (total > 20) total = 20;
    pos = 0;
    if (negative) begin
      tc.char_code = s2da_pkg::CHAR_MINUS;
      tc.text_len = s2da_pkg::LEN_W'(total);
      tc.last_char = (total == 1);
      expected_chars.push_back(tc);
      pos = 1;
    end
    for (int i = ndig - 1; i >= 0 && pos < 20; i--) begin
      tc.char_code = s2da_pkg::CHAR_ZERO + s2da_pkg::CHAR_W'(digits[i]);
      tc.text_len = s2da_pkg::LEN_W'(total);
      tc.last_char = (pos == total - 1);
      expected_chars.push_back(tc);
      pos++;
    end
  endfunction

  // Random value: full range, a chosen digit count, tiny, or near the extremes
  function automatic logic [s2da_pkg::IN_W-1:0] random_value();
    logic [s2da_pkg::IN_W-1:0] low_bound;
    logic [s2da_pkg::IN_W-1:0] span;
    logic [s2da_pkg::IN_W-1:0] v;
    int n;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9)) inside
      [4:7]: begin
        n = $urandom_range(1, 19);
        low_bound = 64'd1;
        for (int i = 1; i < n; i++) low_bound = low_bound * 64'd10;
        span = (low_bound * 64'd10) - low_bound;
        if (n == 1) low_bound = 64'd0;
        if (n == 1) span = 64'd10;
        v = low_bound + ({$urandom, $urandom} % span);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      8: v = 64'($signed($urandom_range(0, 40)) - 20);
      9: begin
        if ($urandom_range(0, 1) == 1) v = {1'b1, 63'd0} + 64'($urandom_range(0, 15));
        else v = {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 15));
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic void queue_value(logic [s2da_pkg::IN_W-1:0] value, bit drain);
    pending_value_t pv;
    pv.value = value;
    pv.hold_for_drain = drain;
    pending_values.push_back(pv);
  endfunction

  // Driver: predicts on each accepted transaction, then presents the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        push_decimal_text(in_value);
        if (burst_left > 0) burst_left--;
      end
      if (!in_valid || !in_stall) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_values.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_values[0].hold_for_drain && expected_chars.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_value <= pending_values[0].value;
          void'(pending_values.pop_front());
        end
      end
    end
  end

  // Monitor: compares each accepted character with the oldest expectation
  always @(posedge clk) begin
    text_char_t exp_tc;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character %0d len %0d last %0d", $time,
                   out_character, out_text_length, out_is_last);
          errors++;
        end else begin
          exp_tc = expected_chars.pop_front();
          if (out_character !== exp_tc.char_code || out_text_length !== exp_tc.text_len ||
              out_is_last !== exp_tc.last_char) begin
            $display("%0t: expected char %0d len %0d last %0d, got char %0d len %0d last %0d",
                     $time, exp_tc.char_code, exp_tc.text_len, exp_tc.last_char,
                     out_character, out_text_length, out_is_last);
            errors++;
          end
        end
      end
      // stall pattern: none, light, heavy or alternating, switching now and then
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(20, 200);
      end else begin
        stall_mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        3: out_stall <= stall_phase[0];
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Stimulus and end of run
  initial begin
    // directed: zero, small, decade edges, extremes, bit patterns
    queue_value(64'd0, 1'b0);
    queue_value(64'd1, 1'b0);
    queue_value(-64'sd1, 1'b0);
    queue_value(64'd9, 1'b0);
    queue_value(64'd10, 1'b0);
    queue_value(-64'sd10, 1'b0);
    queue_value(64'd99, 1'b0);
    queue_value(64'd100, 1'b0);
    queue_value(-64'sd9, 1'b0);
    queue_value(64'd1234567890, 1'b0);
    queue_value(64'd999999999999999999, 1'b0);
    queue_value(64'd1000000000000000000, 1'b0);
    queue_value(-64'sd1000000000000000000, 1'b0);
    queue_value({1'b0, {63{1'b1}}}, 1'b0);
    queue_value({1'b1, 63'd0}, 1'b0);
    queue_value({1'b1, 62'd0, 1'b1}, 1'b0);
    queue_value({32{2'b01}}, 1'b0);
    queue_value({32{2'b10}}, 1'b0);
    queue_value(64'd5, 1'b1);
    queue_value(-64'sd7, 1'b0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      queue_value(random_value(), (i == 100) || ($urandom_range(0, 99) == 0));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
sv/s2da_pkg.sv
sv/s2da_digit_cell.sv
sv/signed_to_decimal_ascii.sv
sim/signed_to_decimal_ascii_test.sv
